// ----- hdl/assert_macros.svh -----
// assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NOW(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NOW(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- hdl/kst_pkg.sv -----
`default_nettype none
package kst_pkg;
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_SORT_PUT,
        ST_EDGE_RD,
        ST_FIND_U,
        ST_FIND_V,
        ST_LINK,
        ST_EMIT,
        ST_SUMMARY
    } state_t;
endpackage
`default_nettype wire

// ----- hdl/kst_if.sv -----
`default_nettype none
interface kst_in_if #(parameter int WEIGHT_BITS = 16);
    logic                   valid;
    logic                   ready;
    logic [5:0]             source_vertex;
    logic [5:0]             target_vertex;
    logic signed [WEIGHT_BITS-1:0] edge_weight;
    logic                   last_edge;
    modport source (output valid, source_vertex, target_vertex, edge_weight, last_edge,
                    input ready);
    modport sink (input valid, source_vertex, target_vertex, edge_weight, last_edge,
                  output ready);
endinterface

interface kst_out_if #(parameter int WEIGHT_BITS = 16);
    logic                   valid;
    logic                   ready;
    logic                   is_summary;
    logic [5:0]             parent_vertex;
    logic [5:0]             child_vertex;
    logic signed [WEIGHT_BITS-1:0] tree_edge_weight;
    logic [5:0]             root_vertex;
    logic [5:0]             root_level;
    logic [5:0]             union_count;
    logic                   root_valid;
    logic                   edge_overflow;
    logic                   last;
    modport source (output valid, is_summary, parent_vertex, child_vertex, tree_edge_weight,
                    root_vertex, root_level, union_count, root_valid, edge_overflow, last,
                    input ready);
    modport sink (input valid, is_summary, parent_vertex, child_vertex, tree_edge_weight,
                  root_vertex, root_level, union_count, root_valid, edge_overflow, last,
                  output ready);
endinterface
`default_nettype wire

// ----- hdl/kruskal_spanning_tree_engine.sv -----
// channel  dir  handshake    payload
// in       in   valid/ready  source_vertex, target_vertex, edge_weight, last_edge
// out      out  valid/ready  tree edges, then one summary item with last
// edges load at one per cycle; after the last edge the block is busy with
// a clear pass over the vertex tables, an insertion sort in the edge memory,
// then per edge a read, a find walk on the first endpoint, a find walk on
// the second and, when the roots differ, a link state and an emit state
// asynchronous reset clears control state; a stalled output holds the block in the link and summary states
`default_nettype none
`include "assert_macros.svh"
module kruskal_spanning_tree_engine #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int WEIGHT_BITS  = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    kst_in_if.sink    in_ch,
    kst_out_if.source out_ch
);
    import kst_pkg::*;

    localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int VA = $clog2(MAX_VERTICES);
    localparam int EW = 12 + WEIGHT_BITS;

    logic [EW-1:0] edge_mem [MAX_EDGES];
    logic [VA-1:0] boss_mem [MAX_VERTICES];
    logic [5:0]    lvl_mem  [MAX_VERTICES];

    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [EW-1:0] key_reg, key_next;
    logic [5:0]    unions_reg, unions_next;
    logic [VA-1:0] root_reg, root_next;
    logic          ovf_reg, ovf_next;
    logic [VA-1:0] x_reg, x_next, ru_reg, ru_next;
    logic [VA-1:0] u_reg, u_next, v_reg, v_next;
    logic [WEIGHT_BITS-1:0] w_reg, w_next;
    logic [6:0]    steps_reg, steps_next;

    logic          ewe;
    logic [EA-1:0] ewa, era;
    logic [EW-1:0] ewd, erd;
    logic          bwe, lwe;
    logic [VA-1:0] bwa, bra, lwa, lra;
    logic [VA-1:0] bwd, brd;
    logic [5:0]    lwd, lrd;

    logic          o_valid_reg, o_valid_next;
    logic          o_sum_reg, o_sum_next;
    logic [5:0]    o_par_reg, o_par_next, o_chi_reg, o_chi_next;
    logic [WEIGHT_BITS-1:0] o_w_reg, o_w_next;
    logic [5:0]    o_root_reg, o_root_next, o_lvl_reg, o_lvl_next, o_uc_reg, o_uc_next;
    logic          o_rv_reg, o_rv_next, o_ov_reg, o_ov_next;

    logic [VA-1:0] lr_ru, lr_rv;
    logic [5:0]    lv_ru_reg, lv_ru_next;

    always_ff @(posedge clk)
    begin
        if (ewe)
        begin
            edge_mem[ewa] <= ewd;
        end
        erd <= edge_mem[era];
        if (bwe)
        begin
            boss_mem[bwa] <= bwd;
        end
        brd <= boss_mem[bra];
        if (lwe)
        begin
            lvl_mem[lwa] <= lwd;
        end
        lrd <= lvl_mem[lra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            unions_reg  <= '0;
            root_reg    <= '0;
            ovf_reg     <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            unions_reg  <= unions_next;
            root_reg    <= root_next;
            ovf_reg     <= ovf_next;
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next; j_reg <= j_next; key_reg <= key_next;
        x_reg <= x_next; ru_reg <= ru_next; u_reg <= u_next; v_reg <= v_next;
        w_reg <= w_next; steps_reg <= steps_next; lv_ru_reg <= lv_ru_next;
        o_sum_reg <= o_sum_next; o_par_reg <= o_par_next; o_chi_reg <= o_chi_next;
        o_w_reg <= o_w_next; o_root_reg <= o_root_next; o_lvl_reg <= o_lvl_next;
        o_uc_reg <= o_uc_next; o_rv_reg <= o_rv_next; o_ov_reg <= o_ov_next;
    end

    logic in_fire, out_free;
    logic v_ok;
    assign out_free = !o_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_LOAD);
    assign in_fire = in_ch.valid && in_ch.ready;
    assign v_ok = (32'(in_ch.source_vertex) < MAX_VERTICES)
               && (32'(in_ch.target_vertex) < MAX_VERTICES);
    assign lr_ru = ru_reg;
    assign lr_rv = x_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg; unions_next = unions_reg; root_next = root_reg;
        ovf_next = ovf_reg;
        i_next = i_reg; j_next = j_reg; key_next = key_reg; x_next = x_reg;
        ru_next = ru_reg; u_next = u_reg; v_next = v_reg; w_next = w_reg;
        steps_next = steps_reg; lv_ru_next = lv_ru_reg;
        o_valid_next = o_valid_reg && !out_ch.ready;
        o_sum_next = o_sum_reg; o_par_next = o_par_reg; o_chi_next = o_chi_reg;
        o_w_next = o_w_reg; o_root_next = o_root_reg; o_lvl_next = o_lvl_reg;
        o_uc_next = o_uc_reg; o_rv_next = o_rv_reg; o_ov_next = o_ov_reg;
        ewe = 1'b0; ewa = '0; ewd = '0; era = '0;
        bwe = 1'b0; bwa = '0; bwd = '0; bra = '0;
        lwe = 1'b0; lwa = '0; lwd = '0; lra = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (v_ok)
                    begin
                        if (32'(count_reg) < MAX_EDGES)
                        begin
                            ewe = 1'b1;
                            ewa = count_reg[EA-1:0];
                            ewd = {in_ch.source_vertex, in_ch.target_vertex,
                                   in_ch.edge_weight};
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (in_ch.last_edge)
                    begin
                        state_next = ST_CLEAR;
                        i_next = '0;
                    end
                end
            end
            ST_CLEAR:
            begin
                bwe = 1'b1; bwa = i_reg[VA-1:0]; bwd = i_reg[VA-1:0];
                lwe = 1'b1; lwa = i_reg[VA-1:0]; lwd = '0;
                i_next = i_reg + 1'b1;
                if (32'(i_reg) == MAX_VERTICES - 1)
                begin
                    i_next = CW'(1);
                    state_next = ST_SORT_RD;
                end
            end
            ST_SORT_RD:
            begin
                if (i_reg >= count_reg)
                begin
                    i_next = '0;
                    state_next = ST_EDGE_RD;
                end
                else
                begin
                    era = i_reg[EA-1:0];
                    j_next = i_reg;
                    state_next = ST_SORT_PUT;
                    steps_next = 7'd1;
                end
            end
            ST_SORT_PUT:
            begin
                // key arrives on first visit, then read j-1
                if (steps_reg[0])
                begin
                    key_next = erd;
                end
                steps_next = '0;
                if (j_reg == '0)
                begin
                    ewe = 1'b1; ewa = j_reg[EA-1:0];
                    ewd = steps_reg[0] ? erd : key_reg;
                    i_next = i_reg + 1'b1;
                    state_next = ST_SORT_RD;
                end
                else
                begin
                    era = EA'(j_reg - 1'b1);
                    state_next = ST_SORT_CMP;
                end
            end
            ST_SORT_CMP:
            begin
                if ($signed(erd[WEIGHT_BITS-1:0]) > $signed(key_reg[WEIGHT_BITS-1:0]))
                begin
                    ewe = 1'b1; ewa = j_reg[EA-1:0]; ewd = erd;
                    j_next = j_reg - 1'b1;
                    state_next = ST_SORT_PUT;
                end
                else
                begin
                    ewe = 1'b1; ewa = j_reg[EA-1:0]; ewd = key_reg;
                    i_next = i_reg + 1'b1;
                    state_next = ST_SORT_RD;
                end
            end
            ST_EDGE_RD:
            begin
                if (i_reg >= count_reg || unions_reg == 6'd63)
                begin
                    state_next = ST_SUMMARY;
                    lra = root_reg;
                end
                else
                begin
                    era = i_reg[EA-1:0];
                    state_next = ST_FIND_U;
                    steps_next = 7'd127;
                end
            end
            ST_FIND_U:
            begin
                if (steps_reg == 7'd127)
                begin
                    u_next = VA'(erd[EW-1 -: 6]);
                    v_next = VA'(erd[EW-7 -: 6]);
                    w_next = erd[WEIGHT_BITS-1:0];
                    x_next = VA'(erd[EW-1 -: 6]);
                    bra = VA'(erd[EW-1 -: 6]);
                    steps_next = '0;
                end
                else if (steps_reg[0])
                begin
                    if (brd == x_reg)
                    begin
                        ru_next = x_reg;
                        x_next = v_reg;
                        bra = v_reg;
                        lra = x_reg;
                        steps_next = '0;
                        state_next = ST_FIND_V;
                    end
                    else
                    begin
                        x_next = brd;
                        bra = brd;
                        steps_next = '0;
                    end
                end
                else
                begin
                    bra = x_reg;
                    steps_next = 7'd1;
                end
            end
            ST_FIND_V:
            begin
                if (steps_reg == '0)
                begin
                    lv_ru_next = lrd;
                    bra = x_reg;
                    steps_next = 7'd1;
                end
                else if (brd == x_reg)
                begin
                    lra = x_reg;
                    if (x_reg == ru_reg)
                    begin
                        i_next = i_reg + 1'b1;
                        state_next = ST_EDGE_RD;
                    end
                    else
                    begin
                        state_next = ST_LINK;
                    end
                end
                else
                begin
                    x_next = brd;
                    bra = brd;
                end
            end
            ST_LINK:
            begin
                // keep the level of the second root on the read port while stalled
                lra = lr_rv;
                if (out_free)
                begin
                    bwe = 1'b1; lwe = 1'b1;
                    o_valid_next = 1'b1; o_sum_next = 1'b0; o_w_next = w_reg;
                    o_root_next = '0; o_lvl_next = '0; o_uc_next = '0;
                    o_rv_next = 1'b0; o_ov_next = 1'b0;
                    if (lrd > lv_ru_reg)
                    begin
                        bwa = lr_ru; bwd = lr_rv; lwa = lr_rv;
                        lwd = (lrd == 6'd63) ? lrd : lrd + 6'd1;
                        root_next = lr_rv;
                        o_par_next = 6'(v_reg); o_chi_next = 6'(u_reg);
                    end
                    else
                    begin
                        bwa = lr_rv; bwd = lr_ru; lwa = lr_ru;
                        lwd = (lv_ru_reg == 6'd63) ? lv_ru_reg : lv_ru_reg + 6'd1;
                        root_next = lr_ru;
                        o_par_next = 6'(u_reg); o_chi_next = 6'(v_reg);
                    end
                    unions_next = unions_reg + 6'd1;
                    i_next = i_reg + 1'b1;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                state_next = ST_EDGE_RD;
            end
            ST_SUMMARY:
            begin
                if (out_free)
                begin
                    o_valid_next = 1'b1; o_sum_next = 1'b1;
                    o_par_next = '0; o_chi_next = '0; o_w_next = '0;
                    o_root_next = 6'(root_reg); o_lvl_next = lrd;
                    o_uc_next = unions_reg; o_rv_next = (unions_reg != '0);
                    o_ov_next = ovf_reg;
                    count_next = '0; unions_next = '0; root_next = '0; ovf_next = 1'b0;
                    state_next = ST_LOAD;
                end
                else
                begin
                    lra = root_reg;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign out_ch.valid = o_valid_reg;
    assign out_ch.is_summary = o_sum_reg;
    assign out_ch.parent_vertex = o_par_reg;
    assign out_ch.child_vertex = o_chi_reg;
    assign out_ch.tree_edge_weight = o_w_reg;
    assign out_ch.root_vertex = o_root_reg;
    assign out_ch.root_level = o_lvl_reg;
    assign out_ch.union_count = o_uc_reg;
    assign out_ch.root_valid = o_rv_reg;
    assign out_ch.edge_overflow = o_ov_reg;
    assign out_ch.last = o_sum_reg;

    `ASSERT_NOW(a_ready_load, clk, rst_n, in_ch.ready == (state_reg == ST_LOAD), "ready outside load")
    `ASSERT_NOW(a_count_max, clk, rst_n, 32'(count_reg) <= MAX_EDGES, "edge count overflow")
    `ASSERT_IMPL(a_link_emit, clk, rst_n, (state_reg == ST_LINK && out_free) |=> o_valid_reg, "link without result")
    `ASSERT_IMPL(a_sum_reset, clk, rst_n, (state_reg == ST_SUMMARY && out_free) |=> (count_reg == '0 && unions_reg == '0), "run state not cleared")
endmodule
`default_nettype wire

// ----- test/kst_checker.sv -----
`timescale 1ns / 100ps
module kst_checker (
    input  logic clk,
    input  logic rst_n,
    kst_in_if    in_ch,
    kst_out_if   out_ch,
    output int   failures,
    output int   pending
);
    typedef struct packed {
        logic        is_summary;
        logic [5:0]  parent_vertex;
        logic [5:0]  child_vertex;
        logic [15:0] tree_edge_weight;
        logic [5:0]  root_vertex;
        logic [5:0]  root_level;
        logic [5:0]  union_count;
        logic        root_valid;
        logic        edge_overflow;
        logic        last;
    } tree_result_t;

    localparam int VERTEX_COUNT = 64;
    localparam int EDGE_SLOTS   = 256;

    tree_result_t      tree_results_due[$];
    logic [5:0]        held_u [EDGE_SLOTS];
    logic [5:0]        held_v [EDGE_SLOTS];
    logic signed [15:0] held_w [EDGE_SLOTS];
    int                held_count;
    logic              dropped_any;

    assign pending = tree_results_due.size();

    function automatic logic [5:0] find_root(input logic [5:0] boss [VERTEX_COUNT],
                                             input logic [5:0] x);
        logic [5:0] r;
        r = x;
        for (int n = 0; n < VERTEX_COUNT; n++)
        begin
            if (boss[r] == r)
                break;
            r = boss[r];
        end
        return r;
    endfunction

    task automatic build_spanning_tree();
        logic [5:0]         boss [VERTEX_COUNT];
        logic [5:0]         level [VERTEX_COUNT];
        logic [5:0]         key_u, key_v, ru, rv, win, winner_root;
        logic signed [15:0] key_w;
        int                 j, unions;
        tree_result_t       r;
        for (int i = 0; i < VERTEX_COUNT; i++)
        begin
            boss[i] = 6'(i);
            level[i] = '0;
        end
        // stable insertion sort by signed weight
        for (int i = 1; i < held_count; i++)
        begin
            key_u = held_u[i];
            key_v = held_v[i];
            key_w = held_w[i];
            j = i;
            while (j > 0 && held_w[j-1] > key_w)
            begin
                held_u[j] = held_u[j-1];
                held_v[j] = held_v[j-1];
                held_w[j] = held_w[j-1];
                j--;
            end
            held_u[j] = key_u;
            held_v[j] = key_v;
            held_w[j] = key_w;
        end
        unions = 0;
        winner_root = '0;
        for (int i = 0; i < held_count; i++)
        begin
            ru = find_root(boss, held_u[i]);
            rv = find_root(boss, held_v[i]);
            if (ru == rv || unions >= 63)
                continue;
            r = '0;
            r.tree_edge_weight = held_w[i];
            if (level[rv] > level[ru])
            begin
                win = rv;
                boss[ru] = rv;
                r.parent_vertex = held_v[i];
                r.child_vertex = held_u[i];
            end
            else
            begin
                win = ru;
                boss[rv] = ru;
                r.parent_vertex = held_u[i];
                r.child_vertex = held_v[i];
            end
            if (level[win] < 63)
                level[win]++;
            winner_root = win;
            unions++;
            tree_results_due.push_back(r);
        end
        r = '0;
        r.is_summary = 1'b1;
        r.root_vertex = winner_root;
        r.root_level = level[winner_root];
        r.union_count = 6'(unions);
        r.root_valid = unions > 0;
        r.edge_overflow = dropped_any;
        r.last = 1'b1;
        tree_results_due.push_back(r);
        held_count = 0;
        dropped_any = 1'b0;
    endtask

    initial
    begin
        failures = 0;
        held_count = 0;
        dropped_any = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            if (held_count < EDGE_SLOTS)
            begin
                held_u[held_count] = in_ch.source_vertex;
                held_v[held_count] = in_ch.target_vertex;
                held_w[held_count] = in_ch.edge_weight;
                held_count++;
            end
            else
                dropped_any = 1'b1;
            if (in_ch.last_edge)
                build_spanning_tree();
        end
    end

    always @(posedge clk)
    begin
        tree_result_t seen, due;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen = {out_ch.is_summary, out_ch.parent_vertex, out_ch.child_vertex,
                    out_ch.tree_edge_weight, out_ch.root_vertex, out_ch.root_level,
                    out_ch.union_count, out_ch.root_valid, out_ch.edge_overflow,
                    out_ch.last};
            if (tree_results_due.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected transfer: %p", seen);
            end
            else
            begin
                due = tree_results_due.pop_front();
                if (seen !== due)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("mismatch: expected %p actual %p", due, seen);
                end
            end
        end
    end
endmodule

// ----- test/kruskal_spanning_tree_engine_test.sv -----
`timescale 1ns / 100ps
module kruskal_spanning_tree_engine_test;
    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    int   cycles;
    int   burst_left;
    bit   hold_request;

    kst_in_if  in_bus ();
    kst_out_if out_bus ();

    kruskal_spanning_tree_engine DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_bus),
        .out_ch (out_bus)
    );

    kst_checker kst_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_bus),
        .out_ch   (out_bus),
        .failures (failures),
        .pending  (pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 3000000)
        begin
            $display("kruskal_spanning_tree_engine_test: FAIL");
            $finish;
        end
    end

    // receiver stall pattern
    initial
    begin
        int mode, span;
        out_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                span = 400;
                mode = 3;
            end
            else
            begin
                span = $urandom_range(5, 60);
                mode = $urandom_range(0, 2);
            end
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    0: out_bus.ready <= 1'b1;
                    1: out_bus.ready <= 1'($urandom_range(0, 1));
                    2: out_bus.ready <= ($urandom_range(0, 3) == 0);
                    default: out_bus.ready <= 1'b0;
                endcase
            end
        end
    end

    task automatic send_edge(input logic [5:0] u, input logic [5:0] v,
                             input logic [15:0] w, input logic fin);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                in_bus.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        in_bus.valid <= 1'b1;
        in_bus.source_vertex <= u;
        in_bus.target_vertex <= v;
        in_bus.edge_weight <= w;
        in_bus.last_edge <= fin;
        do
            @(negedge clk);
        while (!in_bus.ready);
        @(posedge clk);
    endtask

    task automatic random_run(input int n_edges);
        int top_vertex, w_span;
        top_vertex = ($urandom_range(0, 3) == 0) ? 63 : $urandom_range(1, 15);
        w_span = $urandom_range(0, 1) ? 65535 : 7;
        for (int i = 0; i < n_edges; i++)
            send_edge(6'($urandom_range(0, top_vertex)), 6'($urandom_range(0, top_vertex)),
                      (w_span == 7) ? 16'($urandom_range(0, 7) - 4)
                                    : 16'($urandom_range(0, 65535)),
                      i == n_edges - 1);
    endtask

    initial
    begin
        int sent;
        cycles = 0;
        burst_left = 0;
        hold_request = 1'b0;
        rst_n <= 1'b0;
        in_bus.valid <= 1'b0;
        in_bus.source_vertex <= '0;
        in_bus.target_vertex <= '0;
        in_bus.edge_weight <= '0;
        in_bus.last_edge <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, self loop, ties
        send_edge(0, 63, 16'h7fff, 0);
        send_edge(63, 0, 16'h8000, 0);
        send_edge(5, 5, 0, 0);
        send_edge(1, 2, 0, 0);
        send_edge(2, 1, 0, 0);
        send_edge(0, 1, 16'hffff, 1);
        // no union
        send_edge(7, 7, 100, 1);
        // star then merge so levels differ
        send_edge(10, 11, 1, 0);
        send_edge(10, 12, 2, 0);
        send_edge(20, 21, 3, 0);
        send_edge(21, 10, 4, 0);
        send_edge(42, 21, 5, 0);
        send_edge(63, 62, 16'h5555, 0);
        send_edge(62, 20, 16'h2aaa, 1);

        // results held off while the next run is offered
        hold_request = 1'b1;
        sent = 0;
        while (sent < 180)
        begin
            int n;
            n = $urandom_range(1, 24);
            random_run(n);
            sent += n;
        end

        // store overflow, last mark on a dropped edge
        for (int i = 0; i < 258; i++)
            send_edge(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                      16'($urandom_range(0, 65535)), i == 257);
        random_run(3);

        in_bus.valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (failures == 0)
            $display("kruskal_spanning_tree_engine_test: PASS");
        else
            $display("kruskal_spanning_tree_engine_test: FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/kst_pkg.sv
hdl/kst_if.sv
hdl/kruskal_spanning_tree_engine.sv
test/kst_checker.sv
test/kruskal_spanning_tree_engine_test.sv
